/* rtl/aabb_bp_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_bp_pkg
// Shared types and constants of the AABB broadphase pair finder.
// ----------------------------------------------------------------------------
package aabb_bp_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int ID_W         = 10;
    localparam int MASK_W       = 32;
    localparam int CENTRE_W     = 16;
    localparam int EXTENT_W     = 15;
    localparam int PAIR_CNT_W   = 6;

    // results per item are capped; the last one found is marked
    localparam logic [PAIR_CNT_W-1:0] MAX_PAIRS = 6'd63;

    typedef struct packed {
        logic                       frame_start;
        logic [ID_W-1:0]            collider_id;
        logic                       is_active;
        logic [MASK_W-1:0]          group_mask;
        logic [MASK_W-1:0]          filter_mask;
        logic signed [CENTRE_W-1:0] centre_x;
        logic signed [CENTRE_W-1:0] centre_y;
        logic signed [CENTRE_W-1:0] centre_z;
        logic [EXTENT_W-1:0]        extent_x;
        logic [EXTENT_W-1:0]        extent_y;
        logic [EXTENT_W-1:0]        extent_z;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] pair_low_id;
        logic [ID_W-1:0] pair_high_id;
        logic            last_pair;
    } out_item_t;

    // one collider as held in the store
    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic                       active;
        logic [MASK_W-1:0]          group;
        logic [MASK_W-1:0]          filter;
        logic signed [CENTRE_W-1:0] cx;
        logic signed [CENTRE_W-1:0] cy;
        logic signed [CENTRE_W-1:0] cz;
        logic [EXTENT_W-1:0]        ex;
        logic [EXTENT_W-1:0]        ey;
        logic [EXTENT_W-1:0]        ez;
    } coll_t;

    // registered outcome of one pair test
    typedef struct packed {
        logic            valid;
        logic            hit;
        logic [ID_W-1:0] low_id;
        logic [ID_W-1:0] high_id;
    } pair_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

/* rtl/aabb_broadphase_pair_finder_core.sv */
// ----------------------------------------------------------------------------
// aabb_broadphase_pair_finder_core
// Broadphase pair finder: each collider is tested against the colliders of
// the current frame held in one RAM, passing pairs are sent as (low, high).
//
//   channel | ports                       | payload
//   --------+-----------------------------+-------------------------------
//   input   | s_valid, s_ready, s_data    | in_item_t, one collider
//   result  | m_valid, m_ready, m_data    | out_item_t, one pair
//
// An item is handled in steps, with N = colliders stored in the frame (at most
// CAPACITY): accept, N reads from the collider RAM's single read port, the
// registered read, test register, drain check and write; one more step when a
// pair is found, for the flush of the last pair.
// The scan stops early once 63 pairs are found.
// Reset empties the frame at once; the RAM needs no clearing pass.
// A new pair while the pending and the output register are both taken
// freezes the scan until the result channel takes a transfer.
// ----------------------------------------------------------------------------
module aabb_broadphase_pair_finder_core #(
    parameter int CAPACITY = aabb_bp_pkg::DEF_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  aabb_bp_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output aabb_bp_pkg::out_item_t m_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = $bits(aabb_bp_pkg::coll_t);

    aabb_bp_pkg::state_t    state_reg, state_next;
    aabb_bp_pkg::coll_t     cur_reg, cur_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   b_valid_reg, b_valid_next;
    logic [aabb_bp_pkg::PAIR_CNT_W-1:0] hits_reg, hits_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [aabb_bp_pkg::ID_W-1:0] pend_low_reg, pend_low_next;
    logic [aabb_bp_pkg::ID_W-1:0] pend_high_reg, pend_high_next;
    logic                   out_valid_reg, out_valid_next;
    aabb_bp_pkg::out_item_t out_reg, out_next;

    logic                   out_free;
    logic                   more;
    logic                   take_hit;
    logic                   advance;
    logic                   issue;
    logic                   push;
    aabb_bp_pkg::out_item_t push_item;
    logic                   wr_en;
    logic [ENT_W-1:0]       rd_data;
    aabb_bp_pkg::coll_t     entry;
    aabb_bp_pkg::pair_res_t res;

    aabb_bp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (cur_reg),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign entry = aabb_bp_pkg::coll_t'(rd_data);

    aabb_bp_test u_test (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .entry_valid (b_valid_reg),
        .cur         (cur_reg),
        .entry       (entry),
        .res         (res)
    );

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        more     = (rd_idx_reg < count_reg) && (hits_reg != aabb_bp_pkg::MAX_PAIRS);
        take_hit = res.valid && res.hit && (hits_reg != aabb_bp_pkg::MAX_PAIRS);
        // a new hit must push the pending pair out first
        advance  = !(take_hit && pend_valid_reg && !out_free);
        issue    = (state_reg == aabb_bp_pkg::ST_SCAN) && more && advance;

        state_next      = state_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        b_valid_next    = advance ? issue : b_valid_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        pend_low_next   = pend_low_reg;
        pend_high_next  = pend_high_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        push            = 1'b0;
        push_item       = '{pair_low_id: pend_low_reg, pair_high_id: pend_high_reg,
                            last_pair: 1'b0};
        wr_en           = 1'b0;
        s_ready         = 1'b0;

        case (state_reg)
            aabb_bp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cur_next.id     = s_data.collider_id;
                    cur_next.active = s_data.is_active;
                    cur_next.group  = s_data.group_mask;
                    cur_next.filter = s_data.filter_mask;
                    cur_next.cx     = s_data.centre_x;
                    cur_next.cy     = s_data.centre_y;
                    cur_next.cz     = s_data.centre_z;
                    cur_next.ex     = s_data.extent_x;
                    cur_next.ey     = s_data.extent_y;
                    cur_next.ez     = s_data.extent_z;
                    count_next      = s_data.frame_start ? '0 : count_reg;
                    rd_idx_next     = '0;
                    hits_next       = '0;
                    state_next      = aabb_bp_pkg::ST_SCAN;
                end
            end
            aabb_bp_pkg::ST_SCAN: begin
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (take_hit && advance) begin
                    push            = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_low_next   = res.low_id;
                    pend_high_next  = res.high_id;
                    hits_next       = hits_reg + aabb_bp_pkg::PAIR_CNT_W'(1);
                end
                if (!more && !b_valid_reg && !res.valid) begin
                    state_next = aabb_bp_pkg::ST_FLUSH;
                end
            end
            aabb_bp_pkg::ST_FLUSH: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        push                = 1'b1;
                        push_item.last_pair = 1'b1;
                        pend_valid_next     = 1'b0;
                    end
                end else begin
                    // store the collider only while there is room
                    if (count_reg < CNT_W'(CAPACITY)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = aabb_bp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aabb_bp_pkg::ST_IDLE;
            end
        endcase

        if (push) begin
            out_valid_next = 1'b1;
            out_next       = push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= aabb_bp_pkg::ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            b_valid_reg    <= 1'b0;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            b_valid_reg    <= b_valid_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        cur_reg       <= cur_next;
        pend_low_reg  <= pend_low_next;
        pend_high_reg <= pend_high_next;
        out_reg       <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/aabb_bp_ram.sv */
// ----------------------------------------------------------------------------
// aabb_bp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module aabb_bp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/aabb_bp_test.sv */
// ----------------------------------------------------------------------------
// aabb_bp_test
// Pair test of the current collider against one stored collider: id, active,
// group/filter and three-axis box overlap, with the result registered.
// ----------------------------------------------------------------------------
module aabb_bp_test (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  entry_valid,
    input  aabb_bp_pkg::coll_t    cur,
    input  aabb_bp_pkg::coll_t    entry,
    output aabb_bp_pkg::pair_res_t res
);

    function automatic logic axis_overlap(
        input logic signed [aabb_bp_pkg::CENTRE_W-1:0] ca,
        input logic        [aabb_bp_pkg::EXTENT_W-1:0] ea,
        input logic signed [aabb_bp_pkg::CENTRE_W-1:0] cb,
        input logic        [aabb_bp_pkg::EXTENT_W-1:0] eb
    );
        logic signed [aabb_bp_pkg::CENTRE_W:0] d;
        logic        [aabb_bp_pkg::CENTRE_W:0] ad;
        logic        [aabb_bp_pkg::EXTENT_W:0] sum;
        d   = {ca[aabb_bp_pkg::CENTRE_W-1], ca} - {cb[aabb_bp_pkg::CENTRE_W-1], cb};
        ad  = d[aabb_bp_pkg::CENTRE_W] ? -d : d;
        sum = {1'b0, ea} + {1'b0, eb};
        return ad <= {1'b0, sum};
    endfunction

    aabb_bp_pkg::pair_res_t res_reg;
    aabb_bp_pkg::pair_res_t res_next;
    logic                   pass;
    logic                   entry_lower;

    always_comb begin
        pass = (entry.id != cur.id)
            && (cur.active || entry.active)
            && (((cur.group & entry.filter) & (entry.group & cur.filter)) != '0)
            && axis_overlap(cur.cx, cur.ex, entry.cx, entry.ex)
            && axis_overlap(cur.cy, cur.ey, entry.cy, entry.ey)
            && axis_overlap(cur.cz, cur.ez, entry.cz, entry.ez);
        entry_lower      = entry.id < cur.id;
        res_next.valid   = entry_valid;
        res_next.hit     = pass;
        res_next.low_id  = entry_lower ? entry.id : cur.id;
        res_next.high_id = entry_lower ? cur.id : entry.id;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else if (en) begin
            res_reg.valid <= res_next.valid;
        end
        if (en) begin
            res_reg.hit     <= res_next.hit;
            res_reg.low_id  <= res_next.low_id;
            res_reg.high_id <= res_next.high_id;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/aabb_bp_checker.sv */
// ----------------------------------------------------------------------------
// aabb_bp_checker
// Port-level checks of the pair finder, bound to the top level.
// ----------------------------------------------------------------------------
module aabb_bp_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input aabb_bp_pkg::in_item_t  s_data,
    input logic                   m_valid,
    input logic                   m_ready,
    input aabb_bp_pkg::out_item_t m_data
);

    // a held result keeps its value until the transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // same ids are skipped, so a pair is always strictly ordered
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pair_low_id < m_data.pair_high_id)
        else $error("pair ids not strictly ordered");

    // one collider at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    // a pair that is not the last means the item is still in work
    a_not_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_pair |=> !s_ready)
        else $error("input ready before the last pair of an item");

endmodule

bind aabb_broadphase_pair_finder_core aabb_bp_checker u_aabb_bp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* bench/pair_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_checker
// Watches both channels of the broadphase pair finder. Every collider
// transfer is run through a local model of the frame store, which queues
// the overlapping pairs it should cause. Every pair transfer is checked
// field by field against the oldest queued pair.
// ----------------------------------------------------------------------------
module pair_checker #(
    parameter int CAPACITY = aabb_bp_pkg::DEF_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  aabb_bp_pkg::in_item_t  s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  aabb_bp_pkg::out_item_t m_data,
    output int                     mismatch_count,
    output int                     pairs_pending
);

    aabb_bp_pkg::in_item_t  frame_boxes [CAPACITY];
    int                     frame_fill;
    aabb_bp_pkg::out_item_t expected_pairs [$];
    int                     errors;

    initial begin
        mismatch_count = 0;
        pairs_pending  = 0;
        frame_fill     = 0;
        errors         = 0;
    end

    // exact test on one axis: |ca - cb| <= ea + eb
    function automatic bit axis_touch(logic signed [aabb_bp_pkg::CENTRE_W-1:0] ca,
                                      logic [aabb_bp_pkg::EXTENT_W-1:0] ea,
                                      logic signed [aabb_bp_pkg::CENTRE_W-1:0] cb,
                                      logic [aabb_bp_pkg::EXTENT_W-1:0] eb);
        int d;
        d = int'(ca) - int'(cb);
        if (d < 0)
            d = -d;
        return d <= (int'(ea) + int'(eb));
    endfunction

    function automatic void find_pairs(aabb_bp_pkg::in_item_t c);
        aabb_bp_pkg::out_item_t found [$];
        aabb_bp_pkg::out_item_t p;
        aabb_bp_pkg::in_item_t  o;
        if (c.frame_start)
            frame_fill = 0;
        for (int i = 0; i < frame_fill && found.size() < int'(aabb_bp_pkg::MAX_PAIRS);
             i++) begin
            o = frame_boxes[i];
            if (o.collider_id == c.collider_id)
                continue;
            if (!c.is_active && !o.is_active)
                continue;
            if (((c.group_mask & o.filter_mask) & (o.group_mask & c.filter_mask)) == '0)
                continue;
            if (!axis_touch(c.centre_x, c.extent_x, o.centre_x, o.extent_x))
                continue;
            if (!axis_touch(c.centre_y, c.extent_y, o.centre_y, o.extent_y))
                continue;
            if (!axis_touch(c.centre_z, c.extent_z, o.centre_z, o.extent_z))
                continue;
            p.pair_low_id  = (o.collider_id < c.collider_id) ? o.collider_id : c.collider_id;
            p.pair_high_id = (o.collider_id < c.collider_id) ? c.collider_id : o.collider_id;
            p.last_pair    = 1'b0;
            found.push_back(p);
        end
        if (found.size() > 0)
            found[found.size()-1].last_pair = 1'b1;
        foreach (found[k])
            expected_pairs.push_back(found[k]);
        // a full store still tests the collider but keeps it out
        if (frame_fill < CAPACITY) begin
            frame_boxes[frame_fill] = c;
            frame_fill++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        aabb_bp_pkg::out_item_t want;
        if (!aresetn) begin
            frame_fill = 0;
            expected_pairs.delete();
        end else begin
            if (s_valid && s_ready)
                find_pairs(s_data);
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    $display("%0t: unexpected pair, expected none, got low %0d high %0d last %0b",
                             $time, m_data.pair_low_id, m_data.pair_high_id, m_data.last_pair);
                    errors++;
                end else begin
                    want = expected_pairs.pop_front();
                    if (m_data.pair_low_id !== want.pair_low_id ||
                        m_data.pair_high_id !== want.pair_high_id ||
                        m_data.last_pair !== want.last_pair) begin
                        $display("%0t: pair mismatch, expected low %0d high %0d last %0b, %s",
                                 $time, want.pair_low_id, want.pair_high_id, want.last_pair,
                                 $sformatf("got low %0d high %0d last %0b", m_data.pair_low_id,
                                           m_data.pair_high_id, m_data.last_pair));
                        errors++;
                    end
                end
            end
        end
        mismatch_count <= errors;
        pairs_pending  <= expected_pairs.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the broadphase pair finder: a directed frame set covering
// id ordering, repeated ids, activity, mask and axis boundary cases, then
// random frames (crowded, clustered, scattered) under three idling phases.
// Checking is done by pair_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ID_W     = aabb_bp_pkg::ID_W;
    localparam int MASK_W   = aabb_bp_pkg::MASK_W;
    localparam int CENTRE_W = aabb_bp_pkg::CENTRE_W;
    localparam int EXTENT_W = aabb_bp_pkg::EXTENT_W;

    typedef enum int {
        FRAME_CROWD,
        FRAME_CLUSTER,
        FRAME_SCATTER
    } frame_kind_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    aabb_bp_pkg::in_item_t  s_data;
    logic                   m_valid;
    logic                   m_ready;
    aabb_bp_pkg::out_item_t m_data;

    int mismatch_count;
    int pairs_pending;
    int send_idle;
    int recv_idle;

    aabb_broadphase_pair_finder_core #(
        .CAPACITY(aabb_bp_pkg::DEF_CAPACITY)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    pair_checker #(
        .CAPACITY(aabb_bp_pkg::DEF_CAPACITY)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pairs_pending  (pairs_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic aabb_bp_pkg::in_item_t make_collider(
        int fs, int id, int act,
        logic [MASK_W-1:0] grp, logic [MASK_W-1:0] flt,
        int cx, int cy, int cz,
        int ex, int ey, int ez);
        aabb_bp_pkg::in_item_t c;
        c.frame_start = 1'(fs);
        c.collider_id = ID_W'(id);
        c.is_active   = 1'(act);
        c.group_mask  = grp;
        c.filter_mask = flt;
        c.centre_x    = CENTRE_W'(cx);
        c.centre_y    = CENTRE_W'(cy);
        c.centre_z    = CENTRE_W'(cz);
        c.extent_x    = EXTENT_W'(ex);
        c.extent_y    = EXTENT_W'(ey);
        c.extent_z    = EXTENT_W'(ez);
        return c;
    endfunction

    function automatic aabb_bp_pkg::in_item_t random_collider(frame_kind_t kind,
                                                              logic [CENTRE_W-1:0] bx,
                                                              logic [CENTRE_W-1:0] by,
                                                              logic [CENTRE_W-1:0] bz);
        aabb_bp_pkg::in_item_t c;
        c.frame_start = 1'b0;
        // small id pool now and then so ids repeat within a frame
        c.collider_id = ($urandom_range(9) < 3) ? ID_W'($urandom_range(31)) : ID_W'($urandom);
        c.is_active   = 1'($urandom_range(1));
        c.group_mask  = $urandom;
        c.filter_mask = $urandom;
        c.centre_x    = CENTRE_W'($urandom);
        c.centre_y    = CENTRE_W'($urandom);
        c.centre_z    = CENTRE_W'($urandom);
        c.extent_x    = EXTENT_W'($urandom);
        c.extent_y    = EXTENT_W'($urandom);
        c.extent_z    = EXTENT_W'($urandom);
        case (kind)
            FRAME_CROWD: begin
                // everything overlaps everything, drives the pair cap
                c.group_mask[0]  = 1'b1;
                c.filter_mask[0] = 1'b1;
                c.is_active      = ($urandom_range(9) != 0);
                c.centre_x = bx + CENTRE_W'($urandom_range(127)) - CENTRE_W'(64);
                c.centre_y = by + CENTRE_W'($urandom_range(127)) - CENTRE_W'(64);
                c.centre_z = bz + CENTRE_W'($urandom_range(127)) - CENTRE_W'(64);
                c.extent_x = EXTENT_W'($urandom_range(200, 2000));
                c.extent_y = EXTENT_W'($urandom_range(200, 2000));
                c.extent_z = EXTENT_W'($urandom_range(200, 2000));
            end
            FRAME_CLUSTER: begin
                if ($urandom_range(9) != 0) begin
                    c.centre_x = bx + CENTRE_W'($urandom_range(1023)) - CENTRE_W'(512);
                    c.centre_y = by + CENTRE_W'($urandom_range(1023)) - CENTRE_W'(512);
                    c.centre_z = bz + CENTRE_W'($urandom_range(1023)) - CENTRE_W'(512);
                    if ($urandom_range(9) != 0) begin
                        c.extent_x = EXTENT_W'($urandom_range(400));
                        c.extent_y = EXTENT_W'($urandom_range(400));
                        c.extent_z = EXTENT_W'($urandom_range(400));
                    end
                    if ($urandom_range(19) == 0)
                        c.group_mask = '0;
                end
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    task automatic send_collider(input aabb_bp_pkg::in_item_t c);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int n_items, input int s_pct, input int r_pct,
                             input bit with_crowd);
        int                    sent;
        int                    len;
        bit                    first;
        frame_kind_t           kind;
        logic [CENTRE_W-1:0]   bx;
        logic [CENTRE_W-1:0]   by;
        logic [CENTRE_W-1:0]   bz;
        aabb_bp_pkg::in_item_t c;
        send_idle = s_pct;
        recv_idle = r_pct;
        sent      = 0;
        first     = 1'b1;
        while (sent < n_items) begin
            if (first && with_crowd) begin
                // as long as the store or longer; the full-store path is exercised when longer
                kind = FRAME_CROWD;
                len  = $urandom_range(64, 70);
            end else begin
                kind = ($urandom_range(9) < 8) ? FRAME_CLUSTER : FRAME_SCATTER;
                len  = $urandom_range(1, 24);
            end
            first = 1'b0;
            bx = CENTRE_W'($urandom);
            by = CENTRE_W'($urandom);
            bz = CENTRE_W'($urandom);
            for (int k = 0; k < len && sent < n_items; k++) begin
                c = random_collider(kind, bx, by, bz);
                if (k == 0)
                    c.frame_start = 1'b1;
                else if (kind != FRAME_CROWD)
                    c.frame_start = ($urandom_range(49) == 0);
                send_collider(c);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // repeated id is skipped against itself but stored again
        send_collider(make_collider(1, 5, 1, '1, '1, 0, 0, 0, 0, 0, 0));
        send_collider(make_collider(0, 5, 1, '1, '1, 0, 0, 0, 0, 0, 0));
        send_collider(make_collider(0, 3, 0, '1, '1, 0, 0, 0, 0, 0, 0));
        send_collider(make_collider(0, 1023, 0, '0, '1, 0, 0, 0, 0, 0, 0));
        // coordinate extremes, both inactive, exact boundary at full range
        send_collider(make_collider(1, 0, 0, 1, 1, 32767, 32767, 32767, 32767, 32767, 32767));
        send_collider(make_collider(0, 1, 0, 1, 1, 32767, 32767, 32767, 32767, 32767, 32767));
        send_collider(make_collider(0, 2, 1, 1, 1, -32767, -32767, -32767,
                                    32767, 32767, 32767));
        send_collider(make_collider(0, 4, 1, 1, 1, -32768, -32768, -32768,
                                    32767, 32767, 32767));
        // mask product needs a bit common to both directions
        send_collider(make_collider(1, 10, 1, 32'h1, 32'h2, 0, 0, 0, 16, 16, 16));
        send_collider(make_collider(0, 11, 1, 32'h2, 32'h1, 0, 0, 0, 16, 16, 16));
        send_collider(make_collider(0, 12, 1, 32'h3, 32'h3, 0, 0, 0, 16, 16, 16));
        send_collider(make_collider(0, 13, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                                    16, 16, 16));
        send_collider(make_collider(0, 14, 0, '1, '1, 0, 0, 0, 16, 16, 16));
        // axis boundaries: equal touches, one past does not
        send_collider(make_collider(1, 20, 1, '1, '1, 0, 0, 0, 16, 16, 16));
        send_collider(make_collider(0, 21, 1, '1, '1, 32, 0, 0, 16, 16, 16));
        send_collider(make_collider(0, 22, 1, '1, '1, 0, 33, 0, 16, 16, 16));
        send_collider(make_collider(0, 23, 1, '1, '1, 0, 0, -33, 16, 16, 17));
        send_collider(make_collider(0, 19, 1, '1, '1, -33, 0, 0, 16, 16, 16));

        run_phase(84, 28, 67, 1'b1);
        run_phase(84, 67, 28, 1'b0);
        run_phase(84, 0, 0, 1'b1);
        s_valid <= 1'b0;

        // let the checker post the pairs of the last transfer
        @(posedge aclk);
        while (pairs_pending != 0)
            @(posedge aclk);
        // the last collider may still be scanning with no pair to show for it
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && pairs_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
rtl/aabb_bp_pkg.sv
rtl/aabb_bp_ram.sv
rtl/aabb_bp_test.sv
rtl/aabb_broadphase_pair_finder_core.sv
rtl/aabb_bp_checker.sv
bench/pair_checker.sv
bench/tb_top.sv
